// ===== rtl/ppsa_pkg.sv =====
package ppsa_pkg;

  // default build values
  localparam int ANGLE_ITERATIONS_DEF       = 16;
  localparam int POSITION_FRACTION_BITS_DEF = 16;

  // cordic datapath
  localparam int CORDIC_TABLE_LEN = 24;
  localparam int CORDIC_W         = 66;
  localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 66'sd652032874;
  localparam logic [CORDIC_W-1:0] NORM_HI  = 66'h1 << 59;
  localparam logic [CORDIC_W-1:0] NORM_LO  = 66'h1 << 58;
  localparam logic [CORDIC_W-1:0] NORM_FAR = 66'h1 << 50;

  // stream and register port
  localparam int IN_W   = 192;
  localparam int OUT_W  = 96;
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [9:0] SAMPLE_COUNT_RESET = 10'd100;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // arctangent of 2^-i as a 32 bit binary angle
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:    return 32'h20000000;
      5'd1:    return 32'h12E4051E;
      5'd2:    return 32'h09FB385B;
      5'd3:    return 32'h051111D4;
      5'd4:    return 32'h028B0D43;
      5'd5:    return 32'h0145D7E1;
      5'd6:    return 32'h00A2F61E;
      5'd7:    return 32'h00517C55;
      5'd8:    return 32'h0028BE53;
      5'd9:    return 32'h00145F2F;
      5'd10:   return 32'h000A2F98;
      5'd11:   return 32'h000517CC;
      5'd12:   return 32'h00028BE6;
      5'd13:   return 32'h000145F3;
      5'd14:   return 32'h0000A2F9;
      5'd15:   return 32'h0000517C;
      5'd16:   return 32'h000028BE;
      5'd17:   return 32'h0000145F;
      5'd18:   return 32'h00000A2F;
      5'd19:   return 32'h00000517;
      5'd20:   return 32'h0000028B;
      5'd21:   return 32'h00000145;
      5'd22:   return 32'h000000A2;
      5'd23:   return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

  // round a 32 bit binary angle to 16 bits
  function automatic logic signed [15:0] bam16(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h0000_8000;
    return t[31:16];
  endfunction

  // q.30 to q2.14, round half up, clamp to one
  function automatic logic signed [15:0] q30_to_q14(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [16:0] r;
    t = {v[31], v} + 33'sd32768;
    r = t[32:16];
    if (r > 17'sd16384) return 16'sd16384;
    else if (r < -17'sd16384) return -16'sd16384;
    else return r[15:0];
  endfunction

  // saturate to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -40'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/planar_pose_stream_aligner.sv =====
// channel     | direction | transaction contents
// ------------+-----------+--------------------------------------------------
// s_axis      | in        | one reference pose and one source pose, paired
// m_axis      | out       | source pose mapped into the reference frame
// apb         | in/out    | sample_count register at byte address 0
//
// A pair taken before the fit uses one shared 32x32 multiplier for four
// products. An emitted pair is paced by the shared CORDIC unit:
// normalization shifts plus two passes of ANGLE_ITERATIONS
// micro-rotations. The pair that triggers the fit adds four 42 step
// divisions and four 10 step multiplies.
// Reset is synchronous; s_axis_tready is low while a pair is in work and
// while a finished result waits for m_axis_tready.
module planar_pose_stream_aligner #(
  parameter int ANGLE_ITERATIONS       = ppsa_pkg::ANGLE_ITERATIONS_DEF,
  parameter int POSITION_FRACTION_BITS = ppsa_pkg::POSITION_FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // ref_x, ref_y, ref_qw, ref_qz, src_x, src_y, src_qw, src_qz
  input  logic [ppsa_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // aligned_x, aligned_y, aligned_qz, aligned_qw
  output logic [ppsa_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int W = ppsa_pkg::CORDIC_W;

  typedef enum logic [4:0] {
    S_IDLE, S_ACC_MUL, S_ACC_ADD, S_DIV_LOAD, S_DIV_RUN, S_DIV_STORE,
    S_COV_MUL, S_COV_SHIFT, S_COV_NMUL, S_COV_SUB,
    S_FIT_VEC, S_FIT_VEC_WAIT, S_FIT_ROT, S_FIT_ROT_WAIT,
    S_TF_MUL, S_TF_ADD, S_TF_END,
    S_Q_MUL0, S_Q_MUL1, S_Q_VEC, S_Q_VEC_WAIT, S_Q_ROT, S_Q_ROT_WAIT,
    S_EMIT
  } state_t;

  state_t              state;
  logic [9:0]          sample_count;
  logic [9:0]          pairs_seen;
  logic signed [41:0]  sum_pos [4];
  logic [63:0]         sum_prod [4];
  logic                offset_ready;
  logic                fitting;
  logic signed [31:0]  cent [4];
  logic signed [31:0]  off_x, off_y, off_c, off_s;
  logic signed [15:0]  offset_yaw;
  logic signed [31:0]  rx, ry, sx, sy;
  logic signed [15:0]  sqw, sqz;
  logic [1:0]          step;
  logic signed [63:0]  prod, mp, nacc, accx, accy, qy;
  logic [41:0]         div_q;
  logic [9:0]          div_rem;
  logic [5:0]          div_cnt;
  logic                div_neg;
  logic [3:0]          nbit;
  logic [31:0]         rot_angle;
  logic signed [31:0]  res_x, res_y, aligned_x, aligned_y;
  logic signed [15:0]  res_qz, res_qw, aligned_qz, aligned_qw;

  logic signed [31:0]  mul_a, mul_b, ax_sel, ay_sel;
  logic signed [63:0]  prod_sh, rtmp_x, rtmp_y;
  logic signed [33:0]  rnd_x, rnd_y;
  logic [9:0]          n_eff;
  logic [10:0]         trial, trial_diff;
  logic                trial_ge;
  logic signed [41:0]  div_src;
  logic signed [W-1:0] e0, e1, e2, e3, vec_y, vec_x;
  logic signed [39:0]  fit_x_w, fit_y_w, out_x_w, out_y_w;
  logic signed [15:0]  yaw16;
  logic signed [16:0]  yaw_sum;

  ppsa_pkg::cordic_cmd_t  cordic_cmd;
  ppsa_pkg::cordic_stat_t cordic_stat;
  logic [31:0]            cordic_ang;
  logic signed [31:0]     cordic_cos, cordic_sin;

  assign s_axis_tready = (state == S_IDLE);
  assign pready        = 1'b1;
  assign prdata        = (paddr[ppsa_pkg::ADDR_W-1:2] == ppsa_pkg::REG_SAMPLE_COUNT) ?
                         {22'b0, sample_count} : 32'b0;
  assign m_axis_tdata  = {aligned_qw, aligned_qz, aligned_y, aligned_x};

  // shared multiplier operand select
  always_comb begin
    ax_sel = fitting ? cent[2] : sx;
    ay_sel = fitting ? cent[3] : sy;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_ACC_MUL: begin
        mul_a = (step inside {2'd0, 2'd2}) ? sx : sy;
        mul_b = (step inside {2'd0, 2'd3}) ? rx : ry;
      end
      S_COV_MUL: begin
        mul_a = (step inside {2'd0, 2'd2}) ? cent[2] : cent[3];
        mul_b = (step inside {2'd0, 2'd3}) ? cent[0] : cent[1];
      end
      S_TF_MUL: begin
        mul_a = (step inside {2'd0, 2'd3}) ? off_c : off_s;
        mul_b = (step inside {2'd0, 2'd2}) ? ax_sel : ay_sel;
      end
      S_Q_MUL0: begin
        mul_a = {{16{sqw[15]}}, sqw};
        mul_b = {{16{sqz[15]}}, sqz};
      end
      S_Q_MUL1: begin
        mul_a = {{16{sqz[15]}}, sqz};
        mul_b = {{16{sqz[15]}}, sqz};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider step, rounding, widened sums for saturation and angle operands
  always_comb begin
    prod_sh    = prod >>> POSITION_FRACTION_BITS;
    n_eff      = (pairs_seen == '0) ? 10'd1 : pairs_seen;
    trial      = {div_rem, div_q[41]};
    trial_diff = trial - {1'b0, n_eff};
    trial_ge   = (trial >= {1'b0, n_eff});
    div_src    = sum_pos[step];
    rtmp_x     = accx + 64'sd536870912;
    rtmp_y     = accy + 64'sd536870912;
    rnd_x      = rtmp_x[63:30];
    rnd_y      = rtmp_y[63:30];
    fit_x_w    = {{8{cent[0][31]}}, cent[0]} - {{6{rnd_x[33]}}, rnd_x};
    fit_y_w    = {{8{cent[1][31]}}, cent[1]} - {{6{rnd_y[33]}}, rnd_y};
    out_x_w    = {{6{rnd_x[33]}}, rnd_x} + {{8{off_x[31]}}, off_x};
    out_y_w    = {{6{rnd_y[33]}}, rnd_y} + {{8{off_y[31]}}, off_y};
    e0         = {{2{sum_prod[0][63]}}, sum_prod[0]};
    e1         = {{2{sum_prod[1][63]}}, sum_prod[1]};
    e2         = {{2{sum_prod[2][63]}}, sum_prod[2]};
    e3         = {{2{sum_prod[3][63]}}, sum_prod[3]};
    if (state == S_FIT_VEC) begin
      vec_y = (e2 >>> 1) - (e3 >>> 1);
      vec_x = (e0 >>> 1) + (e1 >>> 1);
    end else begin
      vec_y = {{2{qy[63]}}, qy};
      vec_x = (66'sd1 <<< 28) - ({{2{prod[63]}}, prod} <<< 1);
    end
    yaw16   = ppsa_pkg::bam16(cordic_ang);
    yaw_sum = {yaw16[15], yaw16} + {offset_yaw[15], offset_yaw};
  end

  // requests to the cordic unit
  always_comb begin
    cordic_cmd.start     = (state inside {S_FIT_VEC, S_FIT_ROT, S_Q_VEC, S_Q_ROT});
    cordic_cmd.vectoring = (state inside {S_FIT_VEC, S_Q_VEC});
  end

  ppsa_cordic #(
    .ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cordic_cmd),
    .in_y     (vec_y),
    .in_x     (vec_x),
    .in_angle (rot_angle),
    .stat     (cordic_stat),
    .ang_out  (cordic_ang),
    .cos_out  (cordic_cos),
    .sin_out  (cordic_sin)
  );

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_count  <= ppsa_pkg::SAMPLE_COUNT_RESET;
      pairs_seen    <= '0;
      offset_ready  <= 1'b0;
      fitting       <= 1'b0;
      offset_yaw    <= '0;
      off_x         <= '0;
      off_y         <= '0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sum_pos[i]  <= '0;
        sum_prod[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite &&
          (paddr[ppsa_pkg::ADDR_W-1:2] == ppsa_pkg::REG_SAMPLE_COUNT)) begin
        sample_count <= pwdata[9:0];
      end
      // the emit state refills the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            rx   <= s_axis_tdata[31:0];
            ry   <= s_axis_tdata[63:32];
            sx   <= s_axis_tdata[127:96];
            sy   <= s_axis_tdata[159:128];
            sqw  <= s_axis_tdata[175:160];
            sqz  <= s_axis_tdata[191:176];
            step <= '0;
            if (!offset_ready) begin
              sum_pos[0] <= sum_pos[0] + {{10{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
              sum_pos[1] <= sum_pos[1] + {{10{s_axis_tdata[63]}}, s_axis_tdata[63:32]};
              sum_pos[2] <= sum_pos[2] + {{10{s_axis_tdata[127]}}, s_axis_tdata[127:96]};
              sum_pos[3] <= sum_pos[3] + {{10{s_axis_tdata[159]}}, s_axis_tdata[159:128]};
              pairs_seen <= pairs_seen + 1'b1;
              state      <= S_ACC_MUL;
            end else begin
              fitting <= 1'b0;
              state   <= S_TF_MUL;
            end
          end
        end

        // cross-product sums
        S_ACC_MUL: state <= S_ACC_ADD;
        S_ACC_ADD: begin
          sum_prod[step] <= sum_prod[step] + prod_sh;
          if (step == 2'd3) begin
            step <= '0;
            if (pairs_seen >= sample_count) begin
              fitting <= 1'b1;
              state   <= S_DIV_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            step  <= step + 1'b1;
            state <= S_ACC_MUL;
          end
        end

        // centroids, restoring division one bit a cycle
        S_DIV_LOAD: begin
          div_neg <= div_src[41];
          div_q   <= div_src[41] ? -div_src : div_src;
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          div_rem <= trial_ge ? trial_diff[9:0] : trial[9:0];
          div_q   <= {div_q[40:0], trial_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd41) begin
            state <= S_DIV_STORE;
          end
        end
        S_DIV_STORE: begin
          cent[step] <= div_neg ? -div_q[31:0] : div_q[31:0];
          step       <= step + 1'b1;
          state      <= (step == 2'd3) ? S_COV_MUL : S_DIV_LOAD;
        end

        // covariance terms, n times the centroid product by shift and add
        S_COV_MUL: state <= S_COV_SHIFT;
        S_COV_SHIFT: begin
          mp    <= prod_sh;
          nacc  <= '0;
          nbit  <= 4'd9;
          state <= S_COV_NMUL;
        end
        S_COV_NMUL: begin
          nacc <= (nacc <<< 1) + (n_eff[nbit] ? mp : 64'sd0);
          if (nbit == 4'd0) begin
            state <= S_COV_SUB;
          end else begin
            nbit <= nbit - 1'b1;
          end
        end
        S_COV_SUB: begin
          sum_prod[step] <= sum_prod[step] - nacc;
          step           <= step + 1'b1;
          state          <= (step == 2'd3) ? S_FIT_VEC : S_COV_MUL;
        end

        // rotation angle of the fit and its sine and cosine
        S_FIT_VEC: state <= S_FIT_VEC_WAIT;
        S_FIT_VEC_WAIT: begin
          if (cordic_stat.done) begin
            offset_yaw <= yaw16;
            rot_angle  <= {yaw16, 16'b0};
            state      <= S_FIT_ROT;
          end
        end
        S_FIT_ROT: state <= S_FIT_ROT_WAIT;
        S_FIT_ROT_WAIT: begin
          if (cordic_stat.done) begin
            off_c <= cordic_cos;
            off_s <= cordic_sin;
            step  <= '0;
            state <= S_TF_MUL;
          end
        end

        // rotate a position pair by the fitted angle
        S_TF_MUL: state <= S_TF_ADD;
        S_TF_ADD: begin
          case (step)
            2'd0:    accx <= prod;
            2'd1:    accx <= accx - prod;
            2'd2:    accy <= prod;
            default: accy <= accy + prod;
          endcase
          step  <= step + 1'b1;
          state <= (step == 2'd3) ? S_TF_END : S_TF_MUL;
        end
        S_TF_END: begin
          if (fitting) begin
            off_x        <= ppsa_pkg::sat32(fit_x_w);
            off_y        <= ppsa_pkg::sat32(fit_y_w);
            offset_ready <= 1'b1;
            fitting      <= 1'b0;
            state        <= S_TF_MUL;
          end else begin
            res_x <= ppsa_pkg::sat32(out_x_w);
            res_y <= ppsa_pkg::sat32(out_y_w);
            state <= S_Q_MUL0;
          end
        end

        // source yaw, then half-angle sine and cosine of the sum
        S_Q_MUL0: state <= S_Q_MUL1;
        S_Q_MUL1: begin
          qy    <= prod <<< 1;
          state <= S_Q_VEC;
        end
        S_Q_VEC: state <= S_Q_VEC_WAIT;
        S_Q_VEC_WAIT: begin
          if (cordic_stat.done) begin
            rot_angle <= {yaw_sum, 15'b0};
            state     <= S_Q_ROT;
          end
        end
        S_Q_ROT: state <= S_Q_ROT_WAIT;
        S_Q_ROT_WAIT: begin
          if (cordic_stat.done) begin
            res_qz <= ppsa_pkg::q30_to_q14(cordic_sin);
            res_qw <= ppsa_pkg::q30_to_q14(cordic_cos);
            state  <= S_EMIT;
          end
        end

        // hand the result to the output register when it is free
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            aligned_x     <= res_x;
            aligned_y     <= res_y;
            aligned_qz    <= res_qz;
            aligned_qw    <= res_qw;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // results only exist once the offset is fitted
  a_out_after_fit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> offset_ready)
    else $error("result presented before the offset was fitted");

  // the fit is done once per reset
  a_fit_sticky: assert property (@(posedge clk) disable iff (rst)
    offset_ready |=> offset_ready)
    else $error("fitted offset was lost");

  // no more pairs are counted after the fit
  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    offset_ready |=> $stable(pairs_seen))
    else $error("pair count moved after the fit");

  // the cordic unit is never restarted while busy
  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cordic_cmd.start |-> !cordic_stat.busy)
    else $error("cordic started while busy");

endmodule

// ===== rtl/ppsa_cordic.sv =====
module ppsa_cordic #(
  parameter int ITERATIONS = ppsa_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppsa_pkg::cordic_cmd_t                  cmd,
  input  logic signed [ppsa_pkg::CORDIC_W-1:0]   in_y,
  input  logic signed [ppsa_pkg::CORDIC_W-1:0]   in_x,
  input  logic [31:0]                            in_angle,
  output ppsa_pkg::cordic_stat_t                 stat,
  output logic [31:0]                            ang_out,
  output logic signed [31:0]                     cos_out,
  output logic signed [31:0]                     sin_out
);

  localparam int W     = ppsa_pkg::CORDIC_W;
  localparam int ITERS = (ITERATIONS > ppsa_pkg::CORDIC_TABLE_LEN) ?
                         ppsa_pkg::CORDIC_TABLE_LEN : ITERATIONS;
  localparam int CW    = $clog2(ITERS);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} c_state_t;

  c_state_t             c_state;
  logic signed [W-1:0]  x, y;
  logic signed [33:0]   z;
  logic [W-1:0]         m;
  logic [CW-1:0]        cnt;
  logic                 vec_mode;
  logic                 neg;
  logic                 done;

  logic signed [W-1:0]  xs, ys, ys_mag, dx, dy;
  logic [W-1:0]         m0;
  logic [31:0]          tab, a_flip;
  logic                 flip;

  // operand setup at start
  always_comb begin
    xs     = in_x[W-1] ? -in_x : in_x;
    ys     = in_x[W-1] ? -in_y : in_y;
    ys_mag = ys[W-1] ? -ys : ys;
    m0     = (xs > ys_mag) ? xs : ys_mag;
    flip   = (in_angle[31:30] == 2'b01) || (in_angle[31:30] == 2'b10);
    a_flip = flip ? (in_angle + 32'h8000_0000) : in_angle;
  end

  // shifted terms of the current micro-rotation
  always_comb begin
    dx  = y >>> cnt;
    dy  = x >>> cnt;
    tab = ppsa_pkg::atan_entry(5'(cnt));
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      c_state <= C_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (c_state)
        C_IDLE: begin
          if (cmd.start) begin
            cnt      <= '0;
            vec_mode <= cmd.vectoring;
            if (cmd.vectoring) begin
              x       <= xs;
              y       <= ys;
              z       <= in_x[W-1] ? 34'h0_8000_0000 : 34'h0;
              m       <= m0;
              neg     <= 1'b0;
              c_state <= C_NORM;
            end else begin
              x       <= ppsa_pkg::CORDIC_INV_GAIN;
              y       <= '0;
              z       <= {{2{a_flip[31]}}, a_flip};
              neg     <= flip;
              c_state <= C_ITER;
            end
          end
        end
        // bring the larger magnitude into [2^58, 2^59)
        C_NORM: begin
          if (m == '0) begin
            z       <= '0;
            done    <= 1'b1;
            c_state <= C_IDLE;
          end else if (m >= ppsa_pkg::NORM_HI) begin
            x <= x >>> 1;
            y <= y >>> 1;
            m <= m >> 1;
          end else if (m < ppsa_pkg::NORM_FAR) begin
            x <= x <<< 8;
            y <= y <<< 8;
            m <= m << 8;
          end else if (m < ppsa_pkg::NORM_LO) begin
            x <= x <<< 1;
            y <= y <<< 1;
            m <= m << 1;
          end else begin
            c_state <= C_ITER;
          end
        end
        C_ITER: begin
          if (vec_mode) begin
            if (!y[W-1] && (y != '0)) begin
              x <= x + dx;
              y <= y - dy;
              z <= z + {2'b00, tab};
            end else if (y[W-1]) begin
              x <= x - dx;
              y <= y + dy;
              z <= z - {2'b00, tab};
            end
          end else begin
            if (!z[33]) begin
              x <= x - dx;
              y <= y + dy;
              z <= z - {2'b00, tab};
            end else begin
              x <= x + dx;
              y <= y - dy;
              z <= z + {2'b00, tab};
            end
          end
          if (cnt == CW'(ITERS - 1)) begin
            done    <= 1'b1;
            c_state <= C_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: c_state <= C_IDLE;
      endcase
    end
  end

  assign stat.busy = (c_state != C_IDLE);
  assign stat.done = done;
  assign ang_out   = z[31:0];
  assign cos_out   = neg ? -x[31:0] : x[31:0];
  assign sin_out   = neg ? -y[31:0] : y[31:0];

endmodule
